FILE: rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by rotation_matrix_to_quaternion.
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int ELEM_W  = 16;      // matrix element and quaternion width
   localparam int TRACE_W = 18;      // sum of three elements
   localparam int MAG_W   = 17;      // numerator magnitude, also quotient bits
   localparam int Q_MAX   = 32767;
   localparam int Q_MIN   = -32768;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_ROW0  = 2'd1,
      BR_ROW1  = 2'd2,
      BR_ROW2  = 2'd3
   } branch_type;

endpackage

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd), fixed point, fully pipelined.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

//  channel  | ports                                  | dir | role
//  ---------+----------------------------------------+-----+------------------------
//  req      | req_valid, req_stall, req_row*_col*    | in  | one 3x3 matrix, Q1.14
//  rsp      | rsp_valid, rsp_stall, rsp_quat_*,      | out | quaternion + branch
//           | rsp_branch_taken                       |     |
//
//  One request per cycle while req_stall is low. SW = square root bits
//  ((max(FRAC_BITS,17) + 2 + FRAC_BITS) / 2, 16 at the default): one bit of the
//  root per stage, then 17 restoring-division stages, one quotient bit each.
//  Reset (synchronous) clears only the valid bits; payload is not reset.
//  A stalled rsp freezes every stage at once; bubbles are not squeezed out, and
//  req_stall only rises while a result sits in the output register unread.

module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_row0_col0,
   input  logic signed [ELEM_W-1:0] req_row0_col1,
   input  logic signed [ELEM_W-1:0] req_row0_col2,
   input  logic signed [ELEM_W-1:0] req_row1_col0,
   input  logic signed [ELEM_W-1:0] req_row1_col1,
   input  logic signed [ELEM_W-1:0] req_row1_col2,
   input  logic signed [ELEM_W-1:0] req_row2_col0,
   input  logic signed [ELEM_W-1:0] req_row2_col1,
   input  logic signed [ELEM_W-1:0] req_row2_col2,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_quat_w,
   output logic signed [ELEM_W-1:0] rsp_quat_x,
   output logic signed [ELEM_W-1:0] rsp_quat_y,
   output logic signed [ELEM_W-1:0] rsp_quat_z,
   output logic [1:0]               rsp_branch_taken
);

   // radicand width (signed), root bits, divisor bits
   localparam int RW = ((FRAC_BITS > MAG_W) ? FRAC_BITS : MAG_W) + 2;
   localparam int SW = (RW + FRAC_BITS) / 2;
   localparam int VW = 2 * SW;
   localparam int DW = SW + 1;
   localparam int XW = (FRAC_BITS > DW) ? FRAC_BITS : DW;
   localparam int NW = MAG_W + FRAC_BITS;
   localparam int QB = MAG_W;
   localparam logic signed [RW-1:0] ONE = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

   typedef struct packed {
      logic       zero;   // radicand not positive
      branch_type br;
      logic [2:0] neg;    // numerator signs
   } tag_type;

   logic rsp_valid_ff;
   logic advance;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- input register ----------------
   logic                     in_vld_ff;
   logic signed [ELEM_W-1:0] m_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff[0] <= req_row0_col0;
         m_ff[1] <= req_row0_col1;
         m_ff[2] <= req_row0_col2;
         m_ff[3] <= req_row1_col0;
         m_ff[4] <= req_row1_col1;
         m_ff[5] <= req_row1_col2;
         m_ff[6] <= req_row2_col0;
         m_ff[7] <= req_row2_col1;
         m_ff[8] <= req_row2_col2;
      end
   end

   // ---------------- branch select, radicand, numerators ----------------
   logic signed [TRACE_W-1:0] trace;
   logic signed [RW-1:0]      rad;
   branch_type                br_sel;
   logic signed [MAG_W-1:0]   na, nb, nc, nd, ne, nf;
   logic signed [MAG_W-1:0]   num [0:2];
   tag_type                   tag_in;
   logic [MAG_W-1:0]          mag_in [0:2];
   logic [VW-1:0]             v_in;

   always_comb begin
      trace = TRACE_W'(m_ff[0]) + TRACE_W'(m_ff[4]) + TRACE_W'(m_ff[8]);
      priority if (trace > 0) begin
         br_sel = BR_TRACE;
         rad    = ONE + RW'(trace);
      end else if (m_ff[0] > m_ff[4] && m_ff[0] > m_ff[8]) begin
         br_sel = BR_ROW0;
         rad    = ONE + RW'(m_ff[0]) - RW'(m_ff[4]) - RW'(m_ff[8]);
      end else if (m_ff[4] > m_ff[8]) begin
         br_sel = BR_ROW1;
         rad    = ONE + RW'(m_ff[4]) - RW'(m_ff[0]) - RW'(m_ff[8]);
      end else begin
         br_sel = BR_ROW2;
         rad    = ONE + RW'(m_ff[8]) - RW'(m_ff[0]) - RW'(m_ff[4]);
      end

      na = MAG_W'(m_ff[7]) - MAG_W'(m_ff[5]);   // m21 - m12
      nb = MAG_W'(m_ff[2]) - MAG_W'(m_ff[6]);   // m02 - m20
      nc = MAG_W'(m_ff[3]) - MAG_W'(m_ff[1]);   // m10 - m01
      nd = MAG_W'(m_ff[1]) + MAG_W'(m_ff[3]);   // m01 + m10
      ne = MAG_W'(m_ff[2]) + MAG_W'(m_ff[6]);   // m02 + m20
      nf = MAG_W'(m_ff[5]) + MAG_W'(m_ff[7]);   // m12 + m21

      // numerators in component order, skipping the branch's own component
      unique case (br_sel)
         BR_TRACE: begin num[0] = na; num[1] = nb; num[2] = nc; end
         BR_ROW0:  begin num[0] = na; num[1] = nd; num[2] = ne; end
         BR_ROW1:  begin num[0] = nb; num[1] = nd; num[2] = nf; end
         BR_ROW2:  begin num[0] = nc; num[1] = ne; num[2] = nf; end
         default:  begin num[0] = na; num[1] = nb; num[2] = nc; end
      endcase

      tag_in.zero = rad[RW-1] || (rad == '0);
      tag_in.br   = br_sel;
      for (int i = 0; i < 3; i++) begin
         tag_in.neg[i] = num[i][MAG_W-1];
         mag_in[i]     = tag_in.neg[i] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
      end
      v_in = VW'(rad[RW-2:0]) << FRAC_BITS;
   end

   // ---------------- square root, one root bit per stage ----------------
   logic [SW:0]      sq_vld_ff;
   tag_type          sq_tag_ff  [0:SW];
   logic [VW-1:0]    sq_v_ff    [0:SW];
   logic [SW:0]      sq_rem_ff  [0:SW];
   logic [SW-1:0]    sq_root_ff [0:SW];
   logic [MAG_W-1:0] sq_mag_ff  [0:SW][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         sq_vld_ff[0] <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_tag_ff[0]  <= tag_in;
         sq_v_ff[0]    <= v_in;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_mag_ff[0]  <= mag_in;
      end
   end

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [SW+2:0] rem_sh;
      logic [SW+2:0] trial;
      logic          ge;

      always_comb begin
         rem_sh = {sq_rem_ff[k], sq_v_ff[k][2*(SW-1-k)+1 -: 2]};
         trial  = {1'b0, sq_root_ff[k], 2'b01};
         ge     = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_tag_ff[k+1]  <= sq_tag_ff[k];
            sq_v_ff[k+1]    <= sq_v_ff[k];
            sq_rem_ff[k+1]  <= ge ? (SW+1)'(rem_sh - trial) : (SW+1)'(rem_sh);
            sq_root_ff[k+1] <= {sq_root_ff[k][SW-2:0], ge};
            sq_mag_ff[k+1]  <= sq_mag_ff[k];
         end
      end
   end

   // ---------------- divisor, half, overflow pre-check ----------------
   logic [DW-1:0]     dsr;
   logic [ELEM_W-1:0] half;
   logic [NW-1:0]     dvd  [0:2];
   logic [2:0]        ovf_in;
   logic [DW-1:0]     r_in [0:2];
   logic [QB-1:0]     l_in [0:2];

   always_comb begin
      dsr  = {sq_root_ff[SW], 1'b0};
      half = (32'(sq_root_ff[SW] >> 1) > 32'(Q_MAX)) ? ELEM_W'(Q_MAX)
                                                     : ELEM_W'(sq_root_ff[SW] >> 1);
      for (int i = 0; i < 3; i++) begin
         dvd[i]    = NW'(sq_mag_ff[SW][i]) << FRAC_BITS;
         // quotient of 2^17 or more saturates anyway
         ovf_in[i] = XW'(dvd[i][NW-1:QB]) >= XW'(dsr);
         r_in[i]   = DW'(dvd[i][NW-1:QB]);
         l_in[i]   = dvd[i][QB-1:0];
      end
   end

   // ---------------- restoring division, one quotient bit per stage ----------------
   logic [QB:0]       dv_vld_ff;
   tag_type           dv_tag_ff  [0:QB];
   logic [DW-1:0]     dv_d_ff    [0:QB];
   logic [ELEM_W-1:0] dv_half_ff [0:QB];
   logic [2:0]        dv_ovf_ff  [0:QB];
   logic [DW-1:0]     dv_r_ff    [0:QB][0:2];
   logic [QB-1:0]     dv_q_ff    [0:QB][0:2];
   logic [QB-1:0]     dv_l_ff    [0:QB][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= sq_vld_ff[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_tag_ff[0]  <= sq_tag_ff[SW];
         dv_d_ff[0]    <= dsr;
         dv_half_ff[0] <= half;
         dv_ovf_ff[0]  <= ovf_in;
         for (int i = 0; i < 3; i++) begin
            dv_r_ff[0][i] <= r_in[i];
            dv_q_ff[0][i] <= '0;
            dv_l_ff[0][i] <= l_in[i];
         end
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DW:0] rt [0:2];
      logic [2:0]  ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rt[i] = {dv_r_ff[j][i], dv_l_ff[j][i][QB-1-j]};
            ge[i] = rt[i] >= {1'b0, dv_d_ff[j]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_tag_ff[j+1]  <= dv_tag_ff[j];
            dv_d_ff[j+1]    <= dv_d_ff[j];
            dv_half_ff[j+1] <= dv_half_ff[j];
            dv_ovf_ff[j+1]  <= dv_ovf_ff[j];
            for (int i = 0; i < 3; i++) begin
               dv_r_ff[j+1][i] <= ge[i] ? DW'(rt[i] - {1'b0, dv_d_ff[j]}) : DW'(rt[i]);
               dv_q_ff[j+1][i] <= {dv_q_ff[j][i][QB-2:0], ge[i]};
               dv_l_ff[j+1][i] <= dv_l_ff[j][i];
            end
         end
      end
   end

   // ---------------- sign, saturation, placement ----------------
   logic signed [ELEM_W-1:0] comp [0:2];
   logic signed [ELEM_W-1:0] qw_in, qx_in, qy_in, qz_in;
   tag_type                  out_tag;
   logic signed [ELEM_W-1:0] out_half;

   always_comb begin
      out_tag  = dv_tag_ff[QB];
      out_half = ELEM_W'(dv_half_ff[QB]);
      for (int i = 0; i < 3; i++) begin
         if (out_tag.neg[i]) begin
            comp[i] = (dv_ovf_ff[QB][i] || int'(dv_q_ff[QB][i]) > -Q_MIN)
                      ? ELEM_W'(Q_MIN) : ELEM_W'(-(QB+1)'(dv_q_ff[QB][i]));
         end else begin
            comp[i] = (dv_ovf_ff[QB][i] || int'(dv_q_ff[QB][i]) > Q_MAX)
                      ? ELEM_W'(Q_MAX) : ELEM_W'(dv_q_ff[QB][i]);
         end
      end
      unique case (out_tag.br)
         BR_TRACE: begin
            qw_in = out_half; qx_in = comp[0]; qy_in = comp[1]; qz_in = comp[2];
         end
         BR_ROW0: begin
            qw_in = comp[0]; qx_in = out_half; qy_in = comp[1]; qz_in = comp[2];
         end
         BR_ROW1: begin
            qw_in = comp[0]; qx_in = comp[1]; qy_in = out_half; qz_in = comp[2];
         end
         BR_ROW2: begin
            qw_in = comp[0]; qx_in = comp[1]; qy_in = comp[2]; qz_in = out_half;
         end
         default: begin
            qw_in = out_half; qx_in = comp[0]; qy_in = comp[1]; qz_in = comp[2];
         end
      endcase
      if (out_tag.zero) begin
         qw_in = '0;
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
      end
   end

   logic signed [ELEM_W-1:0] rsp_w_ff, rsp_x_ff, rsp_y_ff, rsp_z_ff;
   branch_type               rsp_br_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_w_ff  <= qw_in;
         rsp_x_ff  <= qx_in;
         rsp_y_ff  <= qy_in;
         rsp_z_ff  <= qz_in;
         rsp_br_ff <= out_tag.br;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quat_w       = rsp_w_ff;
   assign rsp_quat_x       = rsp_x_ff;
   assign rsp_quat_y       = rsp_y_ff;
   assign rsp_quat_z       = rsp_z_ff;
   assign rsp_branch_taken = rsp_br_ff;

   // ---------------- assertions ----------------
   // a frozen pipeline keeps every valid bit
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({in_vld_ff, sq_vld_ff, dv_vld_ff, rsp_valid_ff}))
      else $error("pipeline valid bits moved while stalled");

   // root is the floor square root of the radicand shifted left by FRAC_BITS
   a_sqrt: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SW] && !sq_tag_ff[SW].zero |->
         (128'(sq_root_ff[SW]) * 128'(sq_root_ff[SW]) <= 128'(sq_v_ff[SW])) &&
         ((128'(sq_root_ff[SW]) + 128'd1) * (128'(sq_root_ff[SW]) + 128'd1)
            > 128'(sq_v_ff[SW])))
      else $error("square root stage wrong");

   // division remainders stay below the divisor when no overflow
   a_rem: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[QB] && !dv_tag_ff[QB].zero |->
         (dv_ovf_ff[QB][0] || dv_r_ff[QB][0] < dv_d_ff[QB]) &&
         (dv_ovf_ff[QB][1] || dv_r_ff[QB][1] < dv_d_ff[QB]) &&
         (dv_ovf_ff[QB][2] || dv_r_ff[QB][2] < dv_d_ff[QB]))
      else $error("division remainder out of range");

   // a positive radicand never gives a zero divisor
   a_dsr: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[0] && !dv_tag_ff[0].zero |-> dv_d_ff[0] != '0)
      else $error("zero divisor with positive radicand");

endmodule
